>>> sv/pcpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpf_pkg
// shared widths, register map and pair record type for the periodic cutoff
// pair filter
// ----------------------------------------------------------------------------
package pcpf_pkg;

    localparam int IDX_W      = 10;
    localparam int POS_W      = 24;
    localparam int BOX_W      = 23;
    localparam int CUT_W      = 25;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SEP_W      = DIFF_W + 1;
    localparam int SQ_W       = 2 * SEP_W - 2;
    localparam int SUM_W      = SQ_W + 2;
    localparam int CUT2_W     = 2 * CUT_W;
    localparam int NUM_OFF    = 3;
    localparam int NUM_IMAGES = NUM_OFF * NUM_OFF * NUM_OFF;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam int MAX_PARTICLES_DEF = 1024;

    // register indexes, byte address is four times the index
    localparam logic [1:0] REG_BOX_X  = 2'd0;
    localparam logic [1:0] REG_BOX_Y  = 2'd1;
    localparam logic [1:0] REG_BOX_Z  = 2'd2;
    localparam logic [1:0] REG_CUTOFF = 2'd3;

    typedef logic [NUM_OFF-1:0][SEP_W-1:0] sep_set_t;

    // one pair after the cutoff test, image k = 9*ix + 3*iy + iz
    typedef struct packed {
        logic [NUM_IMAGES-1:0] mask;
        sep_set_t              sx;
        sep_set_t              sy;
        sep_set_t              sz;
        logic [IDX_W-1:0]      first;
        logic [IDX_W-1:0]      second;
    } pcpf_pair_t;

endpackage
`default_nettype wire

>>> sv/pcpf_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpf_emit
// holds one tested pair and sends its hits out one per transaction, in image
// order, through a registered output
// ----------------------------------------------------------------------------
module pcpf_emit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               pair_valid,
    input  wire pcpf_pkg::pcpf_pair_t               pair,
    output logic                                    pair_take,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [pcpf_pkg::SEP_W-1:0]       sep_x,
    output logic signed [pcpf_pkg::SEP_W-1:0]       sep_y,
    output logic signed [pcpf_pkg::SEP_W-1:0]       sep_z,
    output logic [pcpf_pkg::IDX_W-1:0]              out_first,
    output logic [pcpf_pkg::IDX_W-1:0]              out_second,
    output logic                                    last
);
    import pcpf_pkg::*;

    pcpf_pair_t            rec_reg;
    logic [NUM_IMAGES-1:0] rem_reg;
    logic [NUM_IMAGES-1:0] rem_next;
    logic [NUM_IMAGES-1:0] pick;
    logic                  busy;
    logic                  load_out;
    logic                  last_pick;
    logic [SEP_W-1:0]      sel_x;
    logic [SEP_W-1:0]      sel_y;
    logic [SEP_W-1:0]      sel_z;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SEP_W-1:0]      sep_x_reg;
    logic [SEP_W-1:0]      sep_y_reg;
    logic [SEP_W-1:0]      sep_z_reg;
    logic [IDX_W-1:0]      first_reg;
    logic [IDX_W-1:0]      second_reg;
    logic                  last_reg;

    assign busy      = |rem_reg;
    assign load_out  = busy && (!out_valid_reg || !out_stall);
    // lowest pending image
    assign pick      = rem_reg & (~rem_reg + NUM_IMAGES'(1));
    assign last_pick = ((rem_reg & ~pick) == '0);
    assign pair_take = !busy || (load_out && last_pick);

    always_comb
    begin
        sel_x = '0;
        sel_y = '0;
        sel_z = '0;
        for (int a = 0; a < NUM_OFF; a++)
        begin
            for (int b = 0; b < NUM_OFF; b++)
            begin
                for (int c = 0; c < NUM_OFF; c++)
                begin
                    sel_x = sel_x | ({SEP_W{pick[a*9 + b*3 + c]}} & rec_reg.sx[a]);
                    sel_y = sel_y | ({SEP_W{pick[a*9 + b*3 + c]}} & rec_reg.sy[b]);
                    sel_z = sel_z | ({SEP_W{pick[a*9 + b*3 + c]}} & rec_reg.sz[c]);
                end
            end
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (load_out)
        begin
            rem_next = rem_reg & ~pick;
        end
        // a pair with no hit loads an empty mask and is gone
        if (pair_take && pair_valid)
        begin
            rem_next = pair.mask;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_take && pair_valid)
        begin
            rec_reg <= pair;
        end
        if (load_out)
        begin
            sep_x_reg  <= sel_x;
            sep_y_reg  <= sel_y;
            sep_z_reg  <= sel_z;
            first_reg  <= rec_reg.first;
            second_reg <= rec_reg.second;
            last_reg   <= last_pick;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sep_x      = $signed(sep_x_reg);
    assign sep_y      = $signed(sep_y_reg);
    assign sep_z      = $signed(sep_z_reg);
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

>>> sv/periodic_cutoff_pair_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_cutoff_pair_filter_unit
// tests one particle pair against all 27 periodic images of the second
// particle and emits every image separation that lies inside the cutoff
// ----------------------------------------------------------------------------
// throughput: one pair per cycle while the output is not stalled; a pair with
//   several hits holds the emitter until its last hit is sent, the single hit
//   register at the end is what sets the rate
// reset: asynchronous active low, clears config registers and all valid bits
// ----------------------------------------------------------------------------
module periodic_cutoff_pair_filter_unit #(
    parameter int MAX_PARTICLES = pcpf_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pcpf_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [pcpf_pkg::DATA_W-1:0]        pwdata,
    output logic [pcpf_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready,
    // pair input
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [pcpf_pkg::IDX_W-1:0]         first_index,
    input  wire logic [pcpf_pkg::IDX_W-1:0]         second_index,
    input  wire logic signed [pcpf_pkg::POS_W-1:0]  first_x,
    input  wire logic signed [pcpf_pkg::POS_W-1:0]  first_y,
    input  wire logic signed [pcpf_pkg::POS_W-1:0]  first_z,
    input  wire logic signed [pcpf_pkg::POS_W-1:0]  second_x,
    input  wire logic signed [pcpf_pkg::POS_W-1:0]  second_y,
    input  wire logic signed [pcpf_pkg::POS_W-1:0]  second_z,
    // hit output
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [pcpf_pkg::SEP_W-1:0]       sep_x,
    output logic signed [pcpf_pkg::SEP_W-1:0]       sep_y,
    output logic signed [pcpf_pkg::SEP_W-1:0]       sep_z,
    output logic [pcpf_pkg::IDX_W-1:0]              out_first,
    output logic [pcpf_pkg::IDX_W-1:0]              out_second,
    output logic                                    last
);
    import pcpf_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [BOX_W-1:0]  box_x_reg;
    logic [BOX_W-1:0]  box_y_reg;
    logic [BOX_W-1:0]  box_z_reg;
    logic [CUT_W-1:0]  cutoff_reg;
    logic [CUT2_W-1:0] cut2_reg;
    logic [CUT2_W-1:0] cut2_next;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg  <= '0;
            box_y_reg  <= '0;
            box_z_reg  <= '0;
            cutoff_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_BOX_X:  box_x_reg  <= pwdata[BOX_W-1:0];
                REG_BOX_Y:  box_y_reg  <= pwdata[BOX_W-1:0];
                REG_BOX_Z:  box_z_reg  <= pwdata[BOX_W-1:0];
                REG_CUTOFF: cutoff_reg <= pwdata[CUT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_BOX_X:  prdata = DATA_W'(box_x_reg);
            REG_BOX_Y:  prdata = DATA_W'(box_y_reg);
            REG_BOX_Z:  prdata = DATA_W'(box_z_reg);
            REG_CUTOFF: prdata = DATA_W'(cutoff_reg);
            default:    prdata = '0;
        endcase
    end

    // squared cutoff kept in a register; config is to change only while idle, the block does not enforce it
    assign cut2_next = CUT2_W'(cutoff_reg) * CUT2_W'(cutoff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut2_reg <= '0;
        end
        else
        begin
            cut2_reg <= cut2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage moves when empty or when the next one moves,
    // so bubbles are squeezed out while the output is stalled
    // ------------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic pair_take;

    assign en4      = !v4_reg || pair_take;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    // ------------------------------------------------------------------
    // stage 1: position differences and index range check
    // ------------------------------------------------------------------
    logic                     idx_ok;
    logic                     v1_next;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [DIFF_W-1:0] dz_next;
    logic signed [DIFF_W-1:0] dx1_reg;
    logic signed [DIFF_W-1:0] dy1_reg;
    logic signed [DIFF_W-1:0] dz1_reg;
    logic [IDX_W-1:0]         fi1_reg;
    logic [IDX_W-1:0]         si1_reg;

    // out of range pairs are dropped right here
    assign idx_ok  = (32'(first_index) < 32'(MAX_PARTICLES))
                  && (32'(second_index) < 32'(MAX_PARTICLES));
    assign v1_next = en1 ? (in_valid && idx_ok) : v1_reg;
    assign dx_next = DIFF_W'(first_x) - DIFF_W'(second_x);
    assign dy_next = DIFF_W'(first_y) - DIFF_W'(second_y);
    assign dz_next = DIFF_W'(first_z) - DIFF_W'(second_z);

    // ------------------------------------------------------------------
    // stage 2: three image separations per axis, offset -1, 0, +1
    // ------------------------------------------------------------------
    sep_set_t         sx_next;
    sep_set_t         sy_next;
    sep_set_t         sz_next;
    sep_set_t         sx2_reg;
    sep_set_t         sy2_reg;
    sep_set_t         sz2_reg;
    logic [IDX_W-1:0] fi2_reg;
    logic [IDX_W-1:0] si2_reg;

    always_comb
    begin
        // offset -1 adds the box, offset +1 subtracts it
        sx_next[0] = SEP_W'(dx1_reg) + SEP_W'(box_x_reg);
        sx_next[1] = SEP_W'(dx1_reg);
        sx_next[2] = SEP_W'(dx1_reg) - SEP_W'(box_x_reg);
        sy_next[0] = SEP_W'(dy1_reg) + SEP_W'(box_y_reg);
        sy_next[1] = SEP_W'(dy1_reg);
        sy_next[2] = SEP_W'(dy1_reg) - SEP_W'(box_y_reg);
        sz_next[0] = SEP_W'(dz1_reg) + SEP_W'(box_z_reg);
        sz_next[1] = SEP_W'(dz1_reg);
        sz_next[2] = SEP_W'(dz1_reg) - SEP_W'(box_z_reg);
    end

    // ------------------------------------------------------------------
    // stage 3: nine squares, each fits in SQ_W bits since |sep| < 1.5 * 2^24
    // ------------------------------------------------------------------
    logic [NUM_OFF-1:0][2*SEP_W-1:0] px;
    logic [NUM_OFF-1:0][2*SEP_W-1:0] py;
    logic [NUM_OFF-1:0][2*SEP_W-1:0] pz;
    logic [NUM_OFF-1:0][SQ_W-1:0]    sqx3_reg;
    logic [NUM_OFF-1:0][SQ_W-1:0]    sqy3_reg;
    logic [NUM_OFF-1:0][SQ_W-1:0]    sqz3_reg;
    sep_set_t                        sx3_reg;
    sep_set_t                        sy3_reg;
    sep_set_t                        sz3_reg;
    logic [IDX_W-1:0]                fi3_reg;
    logic [IDX_W-1:0]                si3_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_OFF; a++)
        begin
            px[a] = $signed(sx2_reg[a]) * $signed(sx2_reg[a]);
            py[a] = $signed(sy2_reg[a]) * $signed(sy2_reg[a]);
            pz[a] = $signed(sz2_reg[a]) * $signed(sz2_reg[a]);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squared length of all 27 images against squared cutoff
    // ------------------------------------------------------------------
    logic [NUM_IMAGES-1:0][SUM_W-1:0] len2;
    logic [NUM_IMAGES-1:0]            hit_next;
    pcpf_pair_t                       pair4_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_OFF; a++)
        begin
            for (int b = 0; b < NUM_OFF; b++)
            begin
                for (int c = 0; c < NUM_OFF; c++)
                begin
                    len2[a*9 + b*3 + c] = SUM_W'(sqx3_reg[a]) + SUM_W'(sqy3_reg[b])
                                        + SUM_W'(sqz3_reg[c]);
                    hit_next[a*9 + b*3 + c] = (len2[a*9 + b*3 + c] < SUM_W'(cut2_reg));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
            dz1_reg <= dz_next;
            fi1_reg <= first_index;
            si1_reg <= second_index;
        end
        if (en2)
        begin
            sx2_reg <= sx_next;
            sy2_reg <= sy_next;
            sz2_reg <= sz_next;
            fi2_reg <= fi1_reg;
            si2_reg <= si1_reg;
        end
        if (en3)
        begin
            for (int a = 0; a < NUM_OFF; a++)
            begin
                sqx3_reg[a] <= px[a][SQ_W-1:0];
                sqy3_reg[a] <= py[a][SQ_W-1:0];
                sqz3_reg[a] <= pz[a][SQ_W-1:0];
            end
            sx3_reg <= sx2_reg;
            sy3_reg <= sy2_reg;
            sz3_reg <= sz2_reg;
            fi3_reg <= fi2_reg;
            si3_reg <= si2_reg;
        end
        if (en4)
        begin
            pair4_reg.mask   <= hit_next;
            pair4_reg.sx     <= sx3_reg;
            pair4_reg.sy     <= sy3_reg;
            pair4_reg.sz     <= sz3_reg;
            pair4_reg.first  <= fi3_reg;
            pair4_reg.second <= si3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5 and output register: serialize the hits of one pair
    // ------------------------------------------------------------------
    pcpf_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (v4_reg),
        .pair       (pair4_reg),
        .pair_take  (pair_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sep_x      (sep_x),
        .sep_y      (sep_y),
        .sep_z      (sep_z),
        .out_first  (out_first),
        .out_second (out_second),
        .last       (last)
    );

endmodule
`default_nettype wire

>>> tb/periodic_cutoff_pair_filter_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_cutoff_pair_filter_unit_tb
// self-checking bench for the periodic cutoff pair filter: pairs go in through
// a driver fed from a backlog queue, a bit-exact predictor builds the list of
// image hits for each accepted pair, and a monitor compares every hit
// transaction field by field, in order, under random idling on both sides
// ----------------------------------------------------------------------------
module periodic_cutoff_pair_filter_unit_tb;

    import pcpf_pkg::*;

    localparam int IDLE_PCT      = 35;     // idle cycles per hundred on each side
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 20;     // lets a pair with no hit drain from the pipe
    localparam int QUIET_LIMIT   = 4000;   // cycles without any transaction
    localparam int POS_MAX       = 8388607;
    localparam int POS_MIN       = -8388608;
    localparam int BOX_MAX       = 8388607;
    localparam int CUT_MAX       = 33554431;

    // one particle pair as offered on the input channel
    typedef struct {
        logic [IDX_W-1:0]        fi;
        logic [IDX_W-1:0]        si;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [POS_W-1:0] az;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic signed [POS_W-1:0] bz;
    } pair_t;

    // one image hit as seen on the output channel
    typedef struct {
        logic [SEP_W-1:0] sx;
        logic [SEP_W-1:0] sy;
        logic [SEP_W-1:0] sz;
        logic [IDX_W-1:0] fi;
        logic [IDX_W-1:0] si;
        logic             lst;
    } hit_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [ADDR_W-1:0]       paddr        = '0;
    logic [DATA_W-1:0]       pwdata       = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic [IDX_W-1:0]        first_index  = '0;
    logic [IDX_W-1:0]        second_index = '0;
    logic signed [POS_W-1:0] first_x      = '0;
    logic signed [POS_W-1:0] first_y      = '0;
    logic signed [POS_W-1:0] first_z      = '0;
    logic signed [POS_W-1:0] second_x     = '0;
    logic signed [POS_W-1:0] second_y     = '0;
    logic signed [POS_W-1:0] second_z     = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic signed [SEP_W-1:0] sep_x;
    logic signed [SEP_W-1:0] sep_y;
    logic signed [SEP_W-1:0] sep_z;
    logic [IDX_W-1:0]        out_first;
    logic [IDX_W-1:0]        out_second;
    logic                    last;

    // shadow copy of the geometry registers, reset values match the block
    logic [BOX_W-1:0] box_x_cfg = '0;
    logic [BOX_W-1:0] box_y_cfg = '0;
    logic [BOX_W-1:0] box_z_cfg = '0;
    logic [CUT_W-1:0] cut_cfg   = '0;

    pair_t pair_backlog[$];     // pairs waiting for the driver
    hit_t  pending_hits[$];     // predicted hits not yet seen on the output
    pair_t cur_pair;

    int    mismatch_count = 0;
    int    quiet_cycles   = 0;
    bit    tx_quiet       = 1'b0;   // sender never idles while set
    bit    rx_quiet       = 1'b0;   // receiver never stalls while set
    int    hold_req       = 0;      // bumped to ask the receiver for a hold-off
    int    hold_seen      = 0;
    int    hold_left      = 0;

    periodic_cutoff_pair_filter_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_index  (first_index),
        .second_index (second_index),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sep_x        (sep_x),
        .sep_y        (sep_y),
        .sep_z        (sep_z),
        .out_first    (out_first),
        .out_second   (out_second),
        .last         (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor: walk the 27 images, x offset outermost, z innermost, and keep
    // every separation strictly inside the cutoff sphere
    // ------------------------------------------------------------------------
    function automatic void image_hits(pair_t p);
        longint dx;
        longint dy;
        longint dz;
        longint sx;
        longint sy;
        longint sz;
        longint lim;
        hit_t   h;
        hit_t   found[$];
        dx  = longint'(p.ax) - longint'(p.bx);
        dy  = longint'(p.ay) - longint'(p.by);
        dz  = longint'(p.az) - longint'(p.bz);
        lim = longint'(cut_cfg) * longint'(cut_cfg);
        for (int ox = -1; ox <= 1; ox++)
        begin
            for (int oy = -1; oy <= 1; oy++)
            begin
                for (int oz = -1; oz <= 1; oz++)
                begin
                    sx = dx - ox * longint'(box_x_cfg);
                    sy = dy - oy * longint'(box_y_cfg);
                    sz = dz - oz * longint'(box_z_cfg);
                    if (sx * sx + sy * sy + sz * sz < lim)
                    begin
                        h.sx  = SEP_W'(sx);
                        h.sy  = SEP_W'(sy);
                        h.sz  = SEP_W'(sz);
                        h.fi  = p.fi;
                        h.si  = p.si;
                        h.lst = 1'b0;
                        found.push_back(h);
                    end
                end
            end
        end
        // the final hit of the pair carries the marker, a miss emits nothing
        if (found.size() != 0)
            found[found.size() - 1].lst = 1'b1;
        foreach (found[k])
            pending_hits.push_back(found[k]);
    endfunction

    function automatic void check_field(string what, logic [SEP_W-1:0] want,
                                        logic [SEP_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch on %s: expected %0h actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: a new pair goes out only when the slot is free; a stalled
    // pair stays on the wires untouched
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // transaction at this edge: predict its hits with the current geometry
            if (in_valid && !in_stall)
                image_hits(cur_pair);
            if (!in_valid || !in_stall)
            begin
                if (pair_backlog.size() != 0 &&
                    (tx_quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_pair = pair_backlog.pop_front();
                    first_index  <= cur_pair.fi;
                    second_index <= cur_pair.si;
                    first_x      <= cur_pair.ax;
                    first_y      <= cur_pair.ay;
                    first_z      <= cur_pair.az;
                    second_x     <= cur_pair.bx;
                    second_y     <= cur_pair.by;
                    second_z     <= cur_pair.bz;
                    in_valid     <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: random, none while rx_quiet, or a counted hold-off when
    // the stimulus asks for one
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left != 1);
        end
        else
        begin
            out_stall <= !rx_quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // output monitor: every hit transaction is matched against the oldest prediction
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t unexpected hit: expected none actual sep %0h %0h %0h idx %0d %0d",
                         $time, sep_x, sep_y, sep_z, out_first, out_second);
                mismatch_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                check_field("sep_x", want.sx, sep_x);
                check_field("sep_y", want.sy, sep_y);
                check_field("sep_z", want.sz, sep_z);
                check_field("out_first", SEP_W'(want.fi), SEP_W'(out_first));
                check_field("out_second", SEP_W'(want.si), SEP_W'(out_second));
                check_field("last", SEP_W'(want.lst), SEP_W'(last));
            end
        end
    end

    // watchdog: too long without a transaction on either channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only called with the block idle, so the shadow can follow at once
    task automatic set_geometry(int unsigned bx, int unsigned by, int unsigned bz,
                                int unsigned cut);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_CUTOFF, cut);
        box_x_cfg = BOX_W'(bx);
        box_y_cfg = BOX_W'(by);
        box_z_cfg = BOX_W'(bz);
        cut_cfg   = CUT_W'(cut);
        @(negedge clk);
    endtask

    // wait for the backlog, the input and the predictions to empty, then let
    // any pair that hits nothing leave the pipe
    task automatic settle_down();
        do @(negedge clk);
        while (pair_backlog.size() != 0 || in_valid || pending_hits.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_pair(int fi, int si, int ax, int ay, int az, int bx, int by, int bz);
        pair_t p;
        p.fi = IDX_W'(fi);
        p.si = IDX_W'(si);
        p.ax = POS_W'(ax);
        p.ay = POS_W'(ay);
        p.az = POS_W'(az);
        p.bx = POS_W'(bx);
        p.by = POS_W'(by);
        p.bz = POS_W'(bz);
        pair_backlog.push_back(p);
    endtask

    // positions inside a span per axis, moved together by a random shift so
    // the separation stays well formed; a share of the pairs are pure noise
    function automatic pair_t draw_pair(int unsigned span_x, int unsigned span_y,
                                        int unsigned span_z, int unsigned noise_pct);
        pair_t p;
        int    shift;
        p.fi = IDX_W'($urandom_range(0, 1023));
        p.si = IDX_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < noise_pct)
        begin
            p.ax = POS_W'($urandom());
            p.ay = POS_W'($urandom());
            p.az = POS_W'($urandom());
            p.bx = POS_W'($urandom());
            p.by = POS_W'($urandom());
            p.bz = POS_W'($urandom());
        end
        else
        begin
            shift = int'($urandom_range(0, 1 << 23)) - (1 << 22);
            p.ax  = POS_W'(int'($urandom_range(0, span_x - 1)) + shift);
            p.bx  = POS_W'(int'($urandom_range(0, span_x - 1)) + shift);
            p.ay  = POS_W'(int'($urandom_range(0, span_y - 1)) + shift);
            p.by  = POS_W'(int'($urandom_range(0, span_y - 1)) + shift);
            p.az  = POS_W'(int'($urandom_range(0, span_z - 1)) + shift);
            p.bz  = POS_W'(int'($urandom_range(0, span_z - 1)) + shift);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned bx;
        int unsigned by;
        int unsigned bz;
        int unsigned lo;
        int          bb;
        int          cc;
        pair_t       p;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: zero box and zero cutoff, nothing may come out
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(1023, 1023, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
        add_pair(5, 6, 1234, -77, 999, 1234, -77, 999);
        settle_down();

        // directed geometry: 256 unit box, cutoff of 4 units
        bb = 1 << 20;
        cc = 1 << 14;
        set_geometry(bb, bb, bb, cc);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);                       // zero separation
        add_pair(1, 2, cc, 0, 0, 0, 0, 0);                      // exactly on the cutoff
        add_pair(3, 4, cc - 1, 0, 0, 0, 0, 0);                  // just inside
        add_pair(5, 6, 0, 0, 0, 0, cc - 1, 0);                  // negative y inside
        add_pair(7, 8, 0, 0, 0, 0, 0, cc);                      // negative z on the cutoff
        add_pair(9, 10, bb - 10, 0, 0, 0, 0, 0);                // wraps through +x image
        add_pair(11, 12, 0, 0, 0, 0, bb - 5, 0);                // wraps through -y image
        add_pair(13, 14, bb - 1, bb - 1, bb - 1, 0, 0, 0);      // corner image
        add_pair(15, 16, 9000, 9000, 9000, 0, 0, 0);            // diagonal inside
        add_pair(17, 18, 9500, 9500, 9500, 0, 0, 0);            // diagonal outside
        add_pair(1023, 1023, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
        add_pair(1023, 0, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
        add_pair(0, 1023, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        add_pair(512, 511, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
        add_pair(682, 341, POS_MIN, POS_MAX, 0, POS_MIN, POS_MAX, 0);
        settle_down();

        // realistic boxes with the cutoff between a quarter and half the shortest edge; the
        // middle set runs with no idling on either side
        for (int k = 0; k < 3; k++)
        begin
            bx = $urandom_range(1 << 19, 1 << 22);
            by = $urandom_range(1 << 19, 1 << 22);
            bz = $urandom_range(1 << 19, 1 << 22);
            lo = (bx < by) ? bx : by;
            lo = (lo < bz) ? lo : bz;
            set_geometry(bx, by, bz, $urandom_range(lo >> 2, lo >> 1));
            tx_quiet = (k == 1);
            rx_quiet = (k == 1);
            repeat (90)
                pair_backlog.push_back(draw_pair(bx, by, bz, 15));
            settle_down();
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
        end

        // zero box: all images coincide, so a hit comes 27 times; the receiver
        // holds off while the sender keeps pushing so the block backs up
        set_geometry(0, 0, 0, 1 << 19);
        @(posedge clk);
        hold_req <= hold_req + 1;
        @(negedge clk);
        tx_quiet = 1'b1;
        repeat (40)
            pair_backlog.push_back(draw_pair(1 << 19, 1 << 19, 1 << 19, 5));
        settle_down();
        tx_quiet = 1'b0;

        // largest box and cutoff over the whole position range
        set_geometry(BOX_MAX, BOX_MAX, BOX_MAX, CUT_MAX);
        repeat (30)
            pair_backlog.push_back(draw_pair(1, 1, 1, 100));
        settle_down();

        // smallest nonzero cutoff: only coincident particles hit
        set_geometry(BOX_MAX, BOX_MAX, BOX_MAX, 1);
        repeat (30)
        begin
            p = draw_pair(1, 1, 1, 100);
            if ($urandom_range(0, 1) != 0)
            begin
                p.bx = p.ax;
                p.by = p.ay;
                p.bz = p.az;
            end
            pair_backlog.push_back(p);
        end
        settle_down();

        // tiny boxes against a wide cutoff: many images hit per pair
        set_geometry(1, $urandom_range(1, 4096), $urandom_range(1, 4096), 1 << 14);
        repeat (30)
            pair_backlog.push_back(draw_pair(1 << 13, 1 << 13, 1 << 13, 10));
        settle_down();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
sv/pcpf_pkg.sv
sv/pcpf_emit.sv
sv/periodic_cutoff_pair_filter_unit.sv
tb/periodic_cutoff_pair_filter_unit_tb.sv
